FILE: rtl/cpio_pkg.sv
// Shared types, event codes and character tables for the cpio newc parser.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package cpio_pkg;

  localparam int unsigned CPIO_Q_DEPTH = 4;

  localparam logic [6:0] HDR_LAST   = 7'd109;
  localparam logic [6:0] MAGIC_LEN  = 7'd6;
  localparam logic [6:0] MAGIC_LAST = 7'd5;
  localparam logic [6:0] FSIZE_LO   = 7'd54;
  localparam logic [6:0] FSIZE_HI   = 7'd61;
  localparam logic [6:0] NSIZE_LO   = 7'd94;
  localparam logic [6:0] NSIZE_HI   = 7'd101;
  localparam logic [31:0] TRAILER_LEN = 32'd10;

  typedef enum logic [2:0] {
    EV_NAME    = 3'd0,
    EV_INFO    = 3'd1,
    EV_DATA    = 3'd2,
    EV_TRAILER = 3'd3,
    EV_BADMAG  = 3'd4
  } cpio_ev_t;

  typedef enum logic [5:0] {
    PH_HDR     = 6'b000001,
    PH_NAME    = 6'b000010,
    PH_NAMEPAD = 6'b000100,
    PH_DATA    = 6'b001000,
    PH_DATAPAD = 6'b010000,
    PH_STOP    = 6'b100000
  } cpio_phase_t;

  typedef struct packed {
    cpio_ev_t    ev;
    logic [7:0]  data;
    logic [31:0] size;
    logic        last;
  } cpio_res_t;

  // ASCII hex digit; anything else decodes as zero
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    return v;
  endfunction

  // "070701"
  function automatic logic [7:0] magic_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h30;
      3'd1:    c = 8'h37;
      3'd2:    c = 8'h30;
      3'd3:    c = 8'h37;
      3'd4:    c = 8'h30;
      3'd5:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "TRAILER!!!"
  function automatic logic [7:0] trailer_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h54;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h4C;
      4'd5:    c = 8'h45;
      4'd6:    c = 8'h52;
      4'd7:    c = 8'h21;
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/cpio_newc_stream_parser.sv
// cpio newc stream parser: one archive byte per word in, name/info/content events out.
// A result is visible (empty low) in the cycle after the byte that caused it is accepted.
// Throughput: one byte per cycle; the front holds off only while the result queue
// (Q_DEPTH words) is full, and the consumer may pop one result per cycle.
// Reset (synchronous, rst_n low): parser at header start, result queue empty.
`timescale 1ns / 1ps

module cpio_newc_stream_parser #(
  parameter int unsigned Q_DEPTH = cpio_pkg::CPIO_Q_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_archive_end,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_byte,
  output logic [31:0] out_entry_size,
  output logic        out_last_of_file
);
  import cpio_pkg::*;

  logic      acc, res_valid;
  cpio_res_t res, head;

  assign acc = push && !full;

  cpio_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc),
    .in_data   (in_data_byte),
    .in_end    (in_archive_end),
    .res_valid (res_valid),
    .res       (res)
  );

  cpio_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res),
    .full    (full),
    .rd_en   (pop),
    .empty   (empty),
    .rd_data (head)
  );

  assign out_event_res    = head.ev;
  assign out_byte         = head.data;
  assign out_entry_size   = head.size;
  assign out_last_of_file = head.last;

endmodule

FILE: rtl/cpio_front.sv
// Front end: byte-serial newc header/name/content walker that classifies each word.
// Depends on cpio_pkg; feeds at most one result per accepted word to the queue.
`timescale 1ns / 1ps

module cpio_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_data,
  input  logic                in_end,
  output logic                res_valid,
  output cpio_pkg::cpio_res_t res
);
  import cpio_pkg::*;

  cpio_phase_t phase_r, phase_nxt;
  logic [6:0]  hdr_idx_r, hdr_idx_nxt;
  logic [31:0] name_len_r, name_len_nxt;
  logic [31:0] cont_len_r, cont_len_nxt;
  logic [31:0] left_r, left_nxt;
  logic        magic_ok_r, magic_ok_nxt;
  logic        trl_r, trl_nxt;
  logic        nul_r, nul_nxt;
  logic [1:0]  pad_r, pad_nxt;

  logic        do_after_name, do_start_data, do_go_hdr;
  logic [31:0] an_nl, an_cl;
  logic [31:0] pos, left_dec;
  logic [1:0]  pad_dec, an_pad, dpad;

  always_comb begin
    phase_nxt    = phase_r;
    hdr_idx_nxt  = hdr_idx_r;
    name_len_nxt = name_len_r;
    cont_len_nxt = cont_len_r;
    left_nxt     = left_r;
    magic_ok_nxt = magic_ok_r;
    trl_nxt      = trl_r;
    nul_nxt      = nul_r;
    pad_nxt      = pad_r;
    res_valid    = 1'b0;
    res          = '0;
    do_after_name = 1'b0;
    do_start_data = 1'b0;
    do_go_hdr     = 1'b0;
    an_nl = name_len_r;
    an_cl = cont_len_r;
    pos      = name_len_r - left_r;
    left_dec = left_r - 32'd1;
    pad_dec  = pad_r - 2'd1;
    an_pad   = 2'd0;
    dpad     = 2'd0;

    case (phase_r)
      PH_HDR: begin
        if (hdr_idx_r == 7'd0) begin
          name_len_nxt = '0;
          cont_len_nxt = '0;
        end
        if (hdr_idx_r < MAGIC_LEN && in_data != magic_char(hdr_idx_r[2:0]))
          magic_ok_nxt = 1'b0;
        if (hdr_idx_r >= FSIZE_LO && hdr_idx_r <= FSIZE_HI)
          cont_len_nxt = {cont_len_nxt[27:0], hex_val(in_data)};
        if (hdr_idx_r >= NSIZE_LO && hdr_idx_r <= NSIZE_HI)
          name_len_nxt = {name_len_nxt[27:0], hex_val(in_data)};
        hdr_idx_nxt = hdr_idx_r + 7'd1;
        if (hdr_idx_r == MAGIC_LAST && !magic_ok_nxt) begin
          res_valid = 1'b1;
          res.ev    = EV_BADMAG;
          phase_nxt = PH_STOP;
        end else if (hdr_idx_r >= HDR_LAST) begin
          if (name_len_nxt == '0) begin
            res_valid = 1'b1;
            res.ev    = EV_INFO;
            res.size  = cont_len_nxt;
            do_after_name = 1'b1;
            an_nl = name_len_nxt;
            an_cl = cont_len_nxt;
          end else begin
            phase_nxt = PH_NAME;
            left_nxt  = name_len_nxt;
            trl_nxt   = 1'b1;
            nul_nxt   = 1'b0;
          end
        end
      end
      PH_NAME: begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          // last byte of the name field terminates it regardless of value
          if (!nul_r && pos != TRAILER_LEN) trl_nxt = 1'b0;
          res_valid = 1'b1;
          if (trl_nxt) begin
            res.ev    = EV_TRAILER;
            phase_nxt = PH_STOP;
          end else begin
            res.ev   = EV_INFO;
            res.size = cont_len_r;
            do_after_name = 1'b1;
          end
        end else if (!nul_r) begin
          if (in_data == 8'h00) begin
            nul_nxt = 1'b1;
            if (pos != TRAILER_LEN) trl_nxt = 1'b0;
          end else begin
            if (pos >= TRAILER_LEN || in_data != trailer_char(pos[3:0])) trl_nxt = 1'b0;
            res_valid = 1'b1;
            res.ev    = EV_NAME;
            res.data  = in_data;
          end
        end
      end
      PH_NAMEPAD: begin
        pad_nxt = pad_dec;
        if (pad_dec == 2'd0) do_start_data = 1'b1;
      end
      PH_DATA: begin
        res_valid = 1'b1;
        res.ev    = EV_DATA;
        res.data  = in_data;
        left_nxt  = left_dec;
        if (left_dec == '0) begin
          res.last = 1'b1;
          dpad     = 2'd0 - cont_len_r[1:0];
          pad_nxt  = dpad;
          if (dpad != 2'd0) phase_nxt = PH_DATAPAD;
          else do_go_hdr = 1'b1;
        end
      end
      PH_DATAPAD: begin
        pad_nxt = pad_dec;
        if (pad_dec == 2'd0) do_go_hdr = 1'b1;
      end
      default: begin
        phase_nxt = PH_STOP;
      end
    endcase

    // name padding aligns 110 + namesize to four bytes
    if (do_after_name) begin
      an_pad  = 2'd2 - an_nl[1:0];
      pad_nxt = an_pad;
      if (an_pad != 2'd0) phase_nxt = PH_NAMEPAD;
      else do_start_data = 1'b1;
    end
    if (do_start_data) begin
      if (an_cl != '0) begin
        phase_nxt = PH_DATA;
        left_nxt  = an_cl;
      end else begin
        pad_nxt   = 2'd0;
        do_go_hdr = 1'b1;
      end
    end
    if (do_go_hdr || in_end) begin
      phase_nxt    = PH_HDR;
      hdr_idx_nxt  = '0;
      magic_ok_nxt = 1'b1;
    end
    if (in_end) begin
      left_nxt = '0;
      pad_nxt  = '0;
      trl_nxt  = 1'b1;
      nul_nxt  = 1'b0;
    end
    if (!in_valid) res_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR;
      hdr_idx_r  <= '0;
      name_len_r <= '0;
      cont_len_r <= '0;
      left_r     <= '0;
      magic_ok_r <= 1'b1;
      trl_r      <= 1'b1;
      nul_r      <= 1'b0;
      pad_r      <= '0;
    end else if (in_valid) begin
      phase_r    <= phase_nxt;
      hdr_idx_r  <= hdr_idx_nxt;
      name_len_r <= name_len_nxt;
      cont_len_r <= cont_len_nxt;
      left_r     <= left_nxt;
      magic_ok_r <= magic_ok_nxt;
      trl_r      <= trl_nxt;
      nul_r      <= nul_nxt;
      pad_r      <= pad_nxt;
    end
  end

endmodule

FILE: rtl/cpio_queue.sv
// Back end: short result queue between the parser and the consumer.
// Depends on cpio_pkg for the result word type.
`timescale 1ns / 1ps

module cpio_queue #(
  parameter int unsigned DEPTH = cpio_pkg::CPIO_Q_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  cpio_pkg::cpio_res_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output logic                empty,
  output cpio_pkg::cpio_res_t rd_data
);
  import cpio_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cpio_res_t     slot_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign rd_data = slot_r[rp_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + PW'(1);
    if (do_rd) rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + PW'(1);
    if (do_wr && !do_rd) cnt_nxt = cnt_r + CW'(1);
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wp_r] <= wr_data;
  end

endmodule

FILE: bench/cpio_newc_stream_parser_tb.sv
// Self-checking bench for cpio_newc_stream_parser: feeds newc archives byte by byte
// and checks every event against an in-bench parser model. Depends on rtl/cpio_pkg.sv.
`timescale 1ns / 1ps

module cpio_newc_stream_parser_tb;
  import cpio_pkg::*;

  localparam logic [47:0] MAGIC_TXT   = "070701";
  localparam logic [79:0] TRAILER_TXT = "TRAILER!!!";
  localparam int BODY_CAP = 64;

  // size field spelling
  localparam int HEX_UPPER = 0;
  localparam int HEX_LOWER = 1;
  localparam int HEX_NOISY = 2;

  // name shapes
  localparam int NAME_PLAIN   = 0;
  localparam int NAME_NULS    = 1;
  localparam int NAME_TRAILER = 2;
  localparam int NAME_NEAR    = 3;
  localparam int NAME_LONG    = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_archive_end = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_byte;
  logic [31:0] out_entry_size;
  logic        out_last_of_file;

  always #6 clk = ~clk;

  cpio_newc_stream_parser dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_data_byte    (in_data_byte),
    .in_archive_end  (in_archive_end),
    .empty           (empty),
    .pop             (pop),
    .out_event_res   (out_event_res),
    .out_byte        (out_byte),
    .out_entry_size  (out_entry_size),
    .out_last_of_file(out_last_of_file)
  );

  class archive_event_board;
    cpio_phase_t phase;
    logic [6:0]  hdr_idx;
    logic [31:0] name_len;
    logic [31:0] file_len;
    logic [31:0] remaining;
    bit          magic_ok;
    bit          trailer_ok;
    bit          nul_seen;
    logic [1:0]  pad;
    cpio_res_t   pending_events[$];
    int          errors;

    function new();
      to_header();
      name_len = '0;
      file_len = '0;
      remaining = '0;
      trailer_ok = 1'b1;
      nul_seen = 1'b0;
      pad = '0;
      errors = 0;
    endfunction

    function void to_header();
      phase = PH_HDR;
      hdr_idx = '0;
      magic_ok = 1'b1;
    endfunction

    function void begin_content_pad();
      pad = 2'd0 - file_len[1:0];
      if (pad != 2'd0) phase = PH_DATAPAD;
      else to_header();
    endfunction

    function void begin_content();
      if (file_len != 0) begin
        phase = PH_DATA;
        remaining = file_len;
      end else begin
        begin_content_pad();
      end
    endfunction

    // newc pads header plus name to 4 bytes; 110 is 2 mod 4
    function void close_name();
      pad = 2'd2 - name_len[1:0];
      if (pad != 2'd0) phase = PH_NAMEPAD;
      else begin_content();
    endfunction

    function logic [3:0] ascii_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
      return 4'd0;
    endfunction

    function void note_byte(logic [7:0] octet, logic arc_end);
      cpio_res_t  r;
      bit         emit;
      logic [6:0] i;
      logic [31:0] pos;
      r = '0;
      emit = 1'b0;
      case (phase)
        PH_HDR: begin
          i = hdr_idx;
          if (i == 7'd0) begin
            name_len = '0;
            file_len = '0;
          end
          if (i < MAGIC_LEN && octet != MAGIC_TXT[8*(5-i) +: 8]) magic_ok = 1'b0;
          if (i >= FSIZE_LO && i <= FSIZE_HI) file_len = {file_len[27:0], ascii_nibble(octet)};
          if (i >= NSIZE_LO && i <= NSIZE_HI) name_len = {name_len[27:0], ascii_nibble(octet)};
          hdr_idx = i + 7'd1;
          if (i == MAGIC_LAST && !magic_ok) begin
            r.ev = EV_BADMAG;
            emit = 1'b1;
            phase = PH_STOP;
          end else if (i == HDR_LAST) begin
            if (name_len == 0) begin
              r.ev = EV_INFO;
              r.size = file_len;
              emit = 1'b1;
              close_name();
            end else begin
              phase = PH_NAME;
              remaining = name_len;
              trailer_ok = 1'b1;
              nul_seen = 1'b0;
            end
          end
        end
        PH_NAME: begin
          pos = name_len - remaining;
          remaining = remaining - 1;
          // last byte of the name field terminates regardless of its value
          if (remaining == 0) begin
            if (!nul_seen && pos != TRAILER_LEN) trailer_ok = 1'b0;
            emit = 1'b1;
            if (trailer_ok) begin
              r.ev = EV_TRAILER;
              phase = PH_STOP;
            end else begin
              r.ev = EV_INFO;
              r.size = file_len;
              close_name();
            end
          end else if (!nul_seen) begin
            if (octet == 8'h00) begin
              nul_seen = 1'b1;
              if (pos != TRAILER_LEN) trailer_ok = 1'b0;
            end else begin
              if (pos >= TRAILER_LEN || octet != TRAILER_TXT[8*(9-pos) +: 8]) trailer_ok = 1'b0;
              r.ev = EV_NAME;
              r.data = octet;
              emit = 1'b1;
            end
          end
        end
        PH_NAMEPAD: begin
          pad = pad - 2'd1;
          if (pad == 2'd0) begin_content();
        end
        PH_DATA: begin
          r.ev = EV_DATA;
          r.data = octet;
          emit = 1'b1;
          remaining = remaining - 1;
          if (remaining == 0) begin
            r.last = 1'b1;
            begin_content_pad();
          end
        end
        PH_DATAPAD: begin
          pad = pad - 2'd1;
          if (pad == 2'd0) to_header();
        end
        default: phase = PH_STOP;
      endcase
      if (arc_end) begin
        to_header();
        remaining = '0;
        pad = '0;
        trailer_ok = 1'b1;
        nul_seen = 1'b0;
      end
      if (emit) pending_events.push_back(r);
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
        errors++;
      end
    endfunction

    function void check_event(cpio_res_t got);
      cpio_res_t want;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual event %0d byte %0h size %0h",
                 $time, got.ev, got.data, got.size);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      compare("event", 32'(want.ev), 32'(got.ev));
      compare("byte", 32'(want.data), 32'(got.data));
      compare("size", want.size, got.size);
      compare("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  archive_event_board board = new();
  logic [7:0] archive_q[$];
  int sent = 0;
  bit push_calm = 1'b0;

  function automatic logic [7:0] pick_octet();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_hex8(logic [31:0] v, int style);
    logic [3:0] d;
    logic [7:0] c;
    bit lead;
    lead = 1'b1;
    for (int k = 7; k >= 0; k--) begin
      d = v[4*k +: 4];
      if (d != 4'd0) lead = 1'b0;
      if (style == HEX_NOISY && lead && $urandom_range(0, 1) == 1) begin
        // non-hex characters decode as zero, so leading zeros may be anything else
        case ($urandom_range(0, 3))
          0:       c = 8'($urandom_range(0, 8'h2f));
          1:       c = 8'($urandom_range(8'h3a, 8'h40));
          2:       c = 8'($urandom_range(8'h47, 8'h60));
          default: c = 8'($urandom_range(8'h67, 8'hff));
        endcase
      end else if (d < 4'd10) begin
        c = 8'h30 + 8'(d);
      end else if (style == HEX_LOWER || (style == HEX_NOISY && $urandom_range(0, 1) == 1)) begin
        c = 8'h57 + 8'(d);
      end else begin
        c = 8'h37 + 8'(d);
      end
      archive_q.push_back(c);
    end
  endfunction

  // one newc entry; bodies are capped, so huge sizes must be cut by the caller
  function automatic void queue_entry(logic [31:0] fsize, logic [31:0] nsize, int style,
                                      int kind);
    logic [1:0] pad;
    logic [7:0] c;
    int body;
    int flip;
    for (int k = 0; k < 6; k++) archive_q.push_back(MAGIC_TXT[8*(5-k) +: 8]);
    for (int f = 0; f < 13; f++) begin
      if (f == 6) push_hex8(fsize, style);
      else if (f == 11) push_hex8(nsize, style);
      else push_hex8($urandom, style);
    end
    flip = $urandom_range(0, 9);
    body = (nsize > BODY_CAP) ? BODY_CAP : int'(nsize);
    for (int k = 0; k < body; k++) begin
      case (kind)
        NAME_NULS:    c = ($urandom_range(0, 3) == 0) ? 8'h00 : pick_octet();
        NAME_TRAILER: c = (k < 10) ? TRAILER_TXT[8*(9-k) +: 8] : 8'h00;
        NAME_NEAR: begin
          c = (k < 10) ? TRAILER_TXT[8*(9-k) +: 8] : 8'h00;
          if (k == flip) c = c ^ 8'h20;
        end
        NAME_LONG: c = (k < 10) ? TRAILER_TXT[8*(9-k) +: 8] : (k == 10) ? "X" : 8'h00;
        default:   c = (k == nsize - 1) ? 8'h00 : 8'($urandom_range(1, 255));
      endcase
      archive_q.push_back(c);
    end
    if (nsize <= BODY_CAP) begin
      pad = 2'd2 - nsize[1:0];
      repeat (pad) archive_q.push_back(pick_octet());
    end
    body = (fsize > BODY_CAP) ? BODY_CAP : int'(fsize);
    repeat (body) archive_q.push_back(pick_octet());
    pad = 2'd0 - fsize[1:0];
    repeat (pad) archive_q.push_back(pick_octet());
  endfunction

  function automatic void trim_archive(int n);
    while (archive_q.size() > n) void'(archive_q.pop_back());
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9))
      7, 8:    return $urandom_range(13, 40);
      9:       return $urandom_range(41, BODY_CAP);
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] octet, input logic last_byte);
    int gap;
    if (sent % 40 == 0) push_calm = ($urandom_range(0, 3) == 0);
    gap = push_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_data_byte <= octet;
    in_archive_end <= last_byte;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_byte(octet, last_byte);
    sent++;
  endtask

  task automatic stream_archive(input bit mark_end);
    int n;
    n = archive_q.size();
    for (int k = 0; k < n; k++) send_byte(archive_q[k], mark_end && k == n - 1);
    archive_q.delete();
  endtask

  // result side
  initial begin
    cpio_res_t seen;
    int gap;
    int served;
    bit pop_calm;
    served = 0;
    pop_calm = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (served % 40 == 0) pop_calm = ($urandom_range(0, 3) == 0);
      gap = pop_calm ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      seen.ev = cpio_ev_t'(out_event_res);
      seen.data = out_byte;
      seen.size = out_entry_size;
      seen.last = out_last_of_file;
      board.check_event(seen);
      served++;
    end
  end

  initial begin
    logic [7:0] c;
    int entries;
    int tail;
    int kind;
    logic [31:0] nsize;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // bad magic at each position, then ignored bytes until the archive end
    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < 6; k++) begin
        c = MAGIC_TXT[8*(5-k) +: 8];
        if (k == p) c = c ^ 8'(1 << $urandom_range(0, 7));
        archive_q.push_back(c);
      end
      repeat (3) archive_q.push_back(pick_octet());
      stream_archive(1'b1);
    end

    queue_entry(3, 0, HEX_LOWER, NAME_PLAIN);          // empty name
    queue_entry(32'h12, 10, HEX_NOISY, NAME_TRAILER);  // one '!' short
    queue_entry(0, 13, HEX_UPPER, NAME_TRAILER);       // trailer, extra NULs after it
    archive_q.push_back(pick_octet());
    stream_archive(1'b1);

    while (sent < 600) begin
      tail = $urandom_range(0, 9);
      if (tail == 9) begin
        // garbage archive
        repeat ($urandom_range(1, 12)) archive_q.push_back(pick_octet());
        stream_archive(1'b1);
      end else begin
        entries = $urandom_range(1, 3);
        repeat (entries) begin
          nsize = $urandom_range(0, 16);
          case ($urandom_range(0, 9))
            0, 1: kind = NAME_NULS;
            2: begin
              kind = NAME_NEAR;
              nsize = 11;
            end
            3: begin
              kind = NAME_LONG;
              nsize = 12;
            end
            default: kind = NAME_PLAIN;
          endcase
          queue_entry(pick_size(), nsize, $urandom_range(0, 2), kind);
        end
        if (tail < 5) begin
          queue_entry(0, 11, $urandom_range(0, 2), NAME_TRAILER);
          repeat ($urandom_range(0, 3)) archive_q.push_back(pick_octet());
        end else if (tail == 8) begin
          if ($urandom_range(0, 1) == 1) queue_entry($urandom, 5, HEX_UPPER, NAME_PLAIN);
          trim_archive($urandom_range(1, archive_q.size()));
        end
        stream_archive(1'b1);
      end
    end
    push <= 1'b0;

    while (board.pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
